>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/xkd_pkg.sv
// ----------------------------------------------------------------------------
// Keyed deframer package
// Types and constants of the keyed length-prefixed deframer.
// ----------------------------------------------------------------------------
package xkd_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int COUNT_BITS   = $clog2(HEADER_BYTES);

   localparam logic       REG_HEADER_KEY  = 1'b0;
   localparam logic       REG_MAX_LENGTH  = 1'b1;
   localparam logic [31:0] KEY_RESET      = 32'h7966_9966;
   localparam logic [23:0] MAX_LEN_RESET  = 24'd16384;

   typedef enum logic [1:0] {
      STATUS_PAYLOAD = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_OVER    = 2'd2
   } status_type;

   typedef struct packed {
      logic [23:0] payload_length;
      logic [31:0] packet_id;
      logic [7:0]  payload_byte;
      status_type  status;
      logic        first_byte;
      logic        last_byte;
   } result_type;

endpackage

>>> src/xor_keyed_length_prefix_deframer_unit.sv
// ----------------------------------------------------------------------------
// Keyed length-prefixed deframer
// Strips an XOR-keyed 8-byte length and id header from each frame of a byte
// stream and passes the payload bytes on, tagged with id, length and marks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_      in         tdata[7:0] received byte
//  rsp_      out        tdata: byte, id, length; tuser: first, status; tlast
//  csr_      in         0 header key, 1 largest payload length
//
// One request is taken every cycle while req_tready is high. Results are
// registered in a two-entry output buffer before they appear on rsp_, so a
// request is still taken while one result waits; req_tready falls only when
// both entries are full. Reset is synchronous and returns the block to
// hunting for a header with the register reset values.
`include "assert_macros.svh"

module xor_keyed_length_prefix_deframer_unit #(
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] payload_byte, [39:8] packet_id,
                                    // [63:40] payload_length
   output logic [2:0]  rsp_tuser,   // [0] first_byte, [2:1] status
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam int CB = xkd_pkg::COUNT_BITS;

   logic [31:0] key_ff;
   logic [23:0] max_len_ff;
   logic [55:0] hdr_ff, hdr_in;
   logic [CB-1:0] count_ff, count_in;
   logic in_payload_ff, in_payload_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [23:0] frame_len_ff, frame_len_in;
   logic [31:0] frame_id_ff, frame_id_in;
   logic first_ff, first_in;

   logic main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   xkd_pkg::result_type main_ff, main_in, skid_ff, skid_in, res;

   logic accept, pop, push, hdr_done, over;
   logic [31:0] len_word, id_word, len_low;

   assign accept   = req_tvalid & req_tready;
   assign pop      = main_valid_ff & rsp_tready;
   assign req_tready = ~skid_valid_ff;

   assign hdr_done = (count_ff == CB'(xkd_pkg::HEADER_BYTES - 1));
   assign len_word = hdr_ff[31:0] ^ key_ff;
   assign id_word  = {req_tdata, hdr_ff[55:32]} ^ key_ff;
   assign len_low  = len_word & LEN_MASK;
   assign over     = (len_word > {8'd0, max_len_ff}) || ((len_word & ~LEN_MASK) != 32'd0);

   always_comb begin
      hdr_in        = hdr_ff;
      count_in      = count_ff;
      in_payload_in = in_payload_ff;
      remain_in     = remain_ff;
      frame_len_in  = frame_len_ff;
      frame_id_in   = frame_id_ff;
      first_in      = first_ff;
      push          = 1'b0;
      res.payload_length = frame_len_ff;
      res.packet_id      = frame_id_ff;
      res.payload_byte   = req_tdata;
      res.status         = xkd_pkg::STATUS_PAYLOAD;
      res.first_byte     = first_ff;
      res.last_byte      = (remain_ff <= LENGTH_BITS'(1));
      if (accept) begin
         if (in_payload_ff) begin
            push     = 1'b1;
            first_in = 1'b0;
            if (remain_ff <= LENGTH_BITS'(1)) begin
               in_payload_in = 1'b0;
               remain_in     = '0;
               count_in      = '0;
            end else begin
               remain_in = remain_ff - LENGTH_BITS'(1);
            end
         end else begin
            hdr_in = {req_tdata, hdr_ff[55:8]};
            if (!hdr_done) begin
               count_in = count_ff + CB'(1);
            end else begin
               count_in           = '0;
               res.payload_length = len_low[23:0];
               res.packet_id      = id_word;
               res.payload_byte   = 8'd0;
               res.first_byte     = 1'b1;
               res.last_byte      = 1'b1;
               if (over) begin
                  push       = 1'b1;
                  res.status = xkd_pkg::STATUS_OVER;
               end else if (len_word == 32'd0) begin
                  push               = 1'b1;
                  res.payload_length = 24'd0;
                  res.status         = xkd_pkg::STATUS_EMPTY;
               end else begin
                  in_payload_in = 1'b1;
                  remain_in     = len_word[LENGTH_BITS-1:0];
                  frame_len_in  = len_low[23:0];
                  frame_id_in   = id_word;
                  first_in      = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= xkd_pkg::KEY_RESET;
         max_len_ff    <= xkd_pkg::MAX_LEN_RESET;
         count_ff      <= '0;
         in_payload_ff <= 1'b0;
         remain_ff     <= '0;
         frame_len_ff  <= '0;
         frame_id_ff   <= '0;
         first_ff      <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               xkd_pkg::REG_HEADER_KEY: key_ff     <= csr_wr_data;
               xkd_pkg::REG_MAX_LENGTH: max_len_ff <= csr_wr_data[23:0];
               default: ;
            endcase
         end
         count_ff      <= count_in;
         in_payload_ff <= in_payload_in;
         remain_ff     <= remain_in;
         frame_len_ff  <= frame_len_in;
         frame_id_ff   <= frame_id_in;
         first_ff      <= first_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {main_ff.payload_length, main_ff.packet_id, main_ff.payload_byte};
   assign rsp_tuser  = {main_ff.status, main_ff.first_byte};
   assign rsp_tlast  = main_ff.last_byte;

   `ASSERT_IMPLIES(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff)
   `ASSERT_IMPLIES(a_payload_has_bytes, clock, reset, in_payload_ff,
      remain_ff != '0 && count_ff == '0)
   `ASSERT_IMPLIES(a_flag_is_single, clock, reset,
      rsp_tvalid && rsp_tuser[2:1] != xkd_pkg::STATUS_PAYLOAD,
      rsp_tlast && rsp_tuser[0])
   `ASSERT_NEXT(a_last_ends_frame, clock, reset,
      accept && in_payload_ff && remain_ff == LENGTH_BITS'(1), !in_payload_ff)

endmodule
